/* hdl/cce_pkg.sv */
// Shared types and constants for the contour curvature endpoint finder.
package cce_pkg;

    localparam int COORD_BITS = 12;
    localparam int IDX_OUT_W  = 12;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DOT_W      = PROD_W + 1;
    localparam int LSCALE_W   = 8;
    localparam int MSEG_W     = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SEGMENTS = 1'b1;

    localparam logic [LSCALE_W-1:0] LSCALE_RESET = 8'd5;
    localparam logic [MSEG_W-1:0]   MSEG_RESET   = 12'd100;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TOO_FEW  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // Dot products must fall below this to count as a curvature extremum.
    localparam logic signed [DOT_W-1:0] CURVY_LIMIT = DOT_W'(1000);

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic   last;
        coord_t point_y;
        coord_t point_x;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [IDX_OUT_W-1:0] tail_index;
        logic [IDX_OUT_W-1:0] head_index;
        coord_t               tail_x;
        coord_t               tail_y;
        coord_t               head_x;
        coord_t               head_y;
    } out_item_t;

    typedef struct packed {
        logic   start;
        coord_t cen_x;
        coord_t cen_y;
        coord_t ahd_x;
        coord_t ahd_y;
        coord_t bhd_x;
        coord_t bhd_y;
    } curv_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [DOT_W-1:0] dot;
        logic                    cross_pos;
    } curv_res_t;

endpackage

/* hdl/contour_curvature_endpoints.sv */
// Contour curvature endpoint finder: stores a closed contour, finds tail and head extrema.
// Load: one point per cycle; ready only while loading, not during evaluation or an output wait.
// Evaluation after the last point: reduce the offset modulo N, then for each of the
// N stored points three RAM reads and four products on the one multiplier, then two
// scans of the curvature RAM; a too-short contour goes straight to the result.
// Reset (aresetn low, synchronous) empties the contour and restores length_scale 5
// and min_segments 100; the point and curvature RAMs are not cleared.
module contour_curvature_endpoints #(
    parameter int MAX_POINTS = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  cce_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output cce_pkg::out_item_t             m_data,
    input  logic                           cfg_we,
    input  logic [cce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cce_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import cce_pkg::*;

    localparam int IW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int KW    = (CW > LSCALE_W) ? CW : LSCALE_W;
    localparam int CMP_W = (CW > MSEG_W + 1) ? CW : MSEG_W + 1;
    localparam int PT_W  = 2 * COORD_BITS;
    localparam int DM_W  = DOT_W + 1;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_POINTS);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_KMOD  = 4'd2;
    localparam logic [3:0] S_RDB   = 4'd3;
    localparam logic [3:0] S_RDC   = 4'd4;
    localparam logic [3:0] S_RDA   = 4'd5;
    localparam logic [3:0] S_RDW   = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_TSCAN = 4'd8;
    localparam logic [3:0] S_HINIT = 4'd9;
    localparam logic [3:0] S_HSCAN = 4'd10;
    localparam logic [3:0] S_PTT   = 4'd11;
    localparam logic [3:0] S_PTH   = 4'd12;
    localparam logic [3:0] S_PTW   = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    // Control state
    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [LSCALE_W-1:0] lscale_reg;
    logic [MSEG_W-1:0]   mseg_reg;
    logic                m_valid_reg, m_valid_next;
    logic                v_reg, v_next;

    // Datapath state
    logic                    few_reg, few_next;
    logic [KW-1:0]           k_reg, k_next;
    logic [CW-1:0]           i_reg, i_next;
    logic [CW-1:0]           vidx_reg;
    logic signed [DOT_W-1:0] best_reg, best_next;
    logic [CW-1:0]           sel_reg, sel_next;
    logic [CW-1:0]           tail_reg, tail_next;
    logic [CW-1:0]           head_reg, head_next;
    coord_t                  bhd_x_reg, bhd_y_reg, cen_x_reg, cen_y_reg;
    coord_t                  tx_reg, ty_reg, hx_reg, hy_reg;
    out_item_t               m_data_reg, m_data_next;

    // RAM ports
    logic            pt_we, dot_we;
    logic [IW-1:0]   pt_raddr;
    logic [PT_W-1:0] pt_rdata;
    logic [DM_W-1:0] dot_rdata;

    // Index arithmetic
    logic [CW-1:0]           kc, bh_idx, hd_idx, dist_a, dist_b, ring_d;
    logic [CW:0]             ah_sum, ah_idx, hd_sum;
    logic signed [DOT_W-1:0] dot_rd;
    logic                    far, hit;

    curv_req_t curv_req;
    curv_res_t curv_res;

    // Ahead and behind neighbors of the center point, wrapped on the ring.
    assign kc     = k_reg[CW-1:0];
    assign ah_sum = {1'b0, i_reg} + {1'b0, kc};
    assign ah_idx = (ah_sum >= {1'b0, count_reg}) ? ah_sum - {1'b0, count_reg} : ah_sum;
    assign bh_idx = (i_reg >= kc) ? i_reg - kc : i_reg + (count_reg - kc);

    // Default head sits opposite the tail.
    assign hd_sum = {1'b0, tail_reg} + {1'b0, (count_reg >> 1)};
    assign hd_idx = (hd_sum >= {1'b0, count_reg}) ? CW'(hd_sum - {1'b0, count_reg})
                                                  : CW'(hd_sum);

    // Ring distance of the scanned point from the tail.
    assign dist_a = (vidx_reg >= tail_reg) ? vidx_reg - tail_reg : tail_reg - vidx_reg;
    assign dist_b = count_reg - dist_a;
    assign ring_d = (dist_a < dist_b) ? dist_a : dist_b;
    assign far    = ring_d > (count_reg >> 2);

    assign dot_rd = $signed(dot_rdata[DOT_W-1:0]);
    assign hit    = v_reg && dot_rdata[DOT_W] && (dot_rd < best_reg)
                    && (state_reg == S_TSCAN || far);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        few_next     = few_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        v_next       = 1'b0;
        best_next    = best_reg;
        sel_next     = sel_reg;
        tail_next    = tail_reg;
        head_next    = head_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        pt_we        = 1'b0;
        dot_we       = 1'b0;
        pt_raddr     = i_reg[IW-1:0];

        unique case (state_reg)
            S_LOAD: if (s_valid) begin
                // Store the point while there is room, otherwise drop it and flag overflow.
                if (count_reg < MAX_C) begin
                    pt_we      = 1'b1;
                    count_next = count_reg + 1'b1;
                end else begin
                    ovf_next = 1'b1;
                end
                if (s_data.last) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (count_reg == '0 ||
                    CMP_W'(count_reg) < CMP_W'({mseg_reg, 1'b0})) begin
                    few_next   = 1'b1;
                    state_next = S_DONE;
                end else begin
                    few_next   = 1'b0;
                    k_next     = KW'(lscale_reg);
                    state_next = S_KMOD;
                end
            end
            S_KMOD: begin
                // Reduce the offset modulo N by repeated subtraction.
                if (k_reg >= KW'(count_reg)) begin
                    k_next = k_reg - KW'(count_reg);
                end else begin
                    i_next     = '0;
                    state_next = S_RDB;
                end
            end
            S_RDB: begin
                pt_raddr   = bh_idx[IW-1:0];
                state_next = S_RDC;
            end
            S_RDC: begin
                pt_raddr   = i_reg[IW-1:0];
                state_next = S_RDA;
            end
            S_RDA: begin
                pt_raddr   = ah_idx[IW-1:0];
                state_next = S_RDW;
            end
            S_RDW: state_next = S_MUL;
            S_MUL: if (curv_res.done) begin
                dot_we = 1'b1;
                if (i_reg == count_reg - 1'b1) begin
                    i_next     = '0;
                    best_next  = CURVY_LIMIT;
                    sel_next   = '0;
                    state_next = S_TSCAN;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RDB;
                end
            end
            S_TSCAN, S_HSCAN: begin
                // Stream through the curvature RAM; compare in the cycle after each read.
                if (i_reg < count_reg) begin
                    i_next = i_reg + 1'b1;
                    v_next = 1'b1;
                end
                if (hit) begin
                    best_next = dot_rd;
                    sel_next  = vidx_reg;
                end
                if (i_reg == count_reg && !v_reg) begin
                    if (state_reg == S_TSCAN) begin
                        tail_next  = sel_reg;
                        state_next = S_HINIT;
                    end else begin
                        head_next  = sel_reg;
                        state_next = S_PTT;
                    end
                end
            end
            S_HINIT: begin
                sel_next   = hd_idx;
                best_next  = CURVY_LIMIT;
                i_next     = '0;
                state_next = S_HSCAN;
            end
            S_PTT: begin
                pt_raddr   = tail_reg[IW-1:0];
                state_next = S_PTH;
            end
            S_PTH: begin
                pt_raddr   = head_reg[IW-1:0];
                state_next = S_PTW;
            end
            S_PTW: state_next = S_DONE;
            S_DONE: if (!m_valid_reg || m_ready) begin
                // Hand the item to the output register and open the next contour.
                m_valid_next = 1'b1;
                if (few_reg) begin
                    m_data_next        = '0;
                    m_data_next.status = STATUS_TOO_FEW;
                end else begin
                    m_data_next.status     = ovf_reg ? STATUS_OVERFLOW : STATUS_OK;
                    m_data_next.tail_index = IDX_OUT_W'(tail_reg);
                    m_data_next.head_index = IDX_OUT_W'(head_reg);
                    m_data_next.tail_x     = tx_reg;
                    m_data_next.tail_y     = ty_reg;
                    m_data_next.head_x     = hx_reg;
                    m_data_next.head_y     = hy_reg;
                end
                count_next = '0;
                ovf_next   = 1'b0;
                state_next = S_LOAD;
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            v_reg       <= 1'b0;
            lscale_reg  <= LSCALE_RESET;
            mseg_reg    <= MSEG_RESET;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            v_reg       <= v_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_LENGTH_SCALE: lscale_reg <= cfg_wdata[LSCALE_W-1:0];
                    REG_MIN_SEGMENTS: mseg_reg   <= cfg_wdata[MSEG_W-1:0];
                    default:          lscale_reg <= lscale_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        few_reg    <= few_next;
        k_reg      <= k_next;
        i_reg      <= i_next;
        vidx_reg   <= i_reg;
        best_reg   <= best_next;
        sel_reg    <= sel_next;
        tail_reg   <= tail_next;
        head_reg   <= head_next;
        m_data_reg <= m_data_next;
        // Capture neighbor and endpoint coordinates as the reads return.
        if (state_reg == S_RDC) begin
            bhd_x_reg <= pt_rdata[COORD_BITS-1:0];
            bhd_y_reg <= pt_rdata[PT_W-1:COORD_BITS];
        end
        if (state_reg == S_RDA) begin
            cen_x_reg <= pt_rdata[COORD_BITS-1:0];
            cen_y_reg <= pt_rdata[PT_W-1:COORD_BITS];
        end
        if (state_reg == S_PTH) begin
            tx_reg <= pt_rdata[COORD_BITS-1:0];
            ty_reg <= pt_rdata[PT_W-1:COORD_BITS];
        end
        if (state_reg == S_PTW) begin
            hx_reg <= pt_rdata[COORD_BITS-1:0];
            hy_reg <= pt_rdata[PT_W-1:COORD_BITS];
        end
    end

    cce_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (count_reg[IW-1:0]),
        .wdata ({s_data.point_y, s_data.point_x}),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    cce_ram #(
        .WIDTH (DM_W),
        .DEPTH (MAX_POINTS)
    ) u_dot_ram (
        .aclk  (aclk),
        .we    (dot_we),
        .waddr (i_reg[IW-1:0]),
        .wdata ({curv_res.cross_pos, curv_res.dot}),
        .raddr (i_reg[IW-1:0]),
        .rdata (dot_rdata)
    );

    // The ahead point goes straight from the RAM output into the unit.
    assign curv_req.start = (state_reg == S_RDW);
    assign curv_req.cen_x = cen_x_reg;
    assign curv_req.cen_y = cen_y_reg;
    assign curv_req.bhd_x = bhd_x_reg;
    assign curv_req.bhd_y = bhd_y_reg;
    assign curv_req.ahd_x = pt_rdata[COORD_BITS-1:0];
    assign curv_req.ahd_y = pt_rdata[PT_W-1:COORD_BITS];

    cce_curv u_curv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (curv_req),
        .res     (curv_res)
    );

    assign s_ready = (state_reg == S_LOAD);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The point store never holds more than its depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_C)
        else $error("point count exceeds store depth");

    // Neighbor reads start only once the offset has been reduced below N.
    a_k_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RDB |-> k_reg < KW'(count_reg))
        else $error("offset not reduced before neighbor reads");

    // The curvature unit finishes only while the sequencer waits for it.
    a_curv_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        curv_res.done |-> state_reg == S_MUL)
        else $error("curvature result arrived outside the multiply wait");

    // Both endpoints lie on the stored contour when a full result is issued.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && !few_reg) |-> (tail_reg < count_reg && head_reg < count_reg))
        else $error("endpoint index outside the contour");

endmodule

/* hdl/cce_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module cce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/cce_curv.sv */
// Curvature unit: dot product and cross sign of ahead and behind vectors on one multiplier.
module cce_curv (
    input  logic                aclk,
    input  logic                aresetn,
    input  cce_pkg::curv_req_t  req,
    output cce_pkg::curv_res_t  res
);
    import cce_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_XX    = 3'd1;
    localparam logic [2:0] ST_YY    = 3'd2;
    localparam logic [2:0] ST_XY    = 3'd3;
    localparam logic [2:0] ST_YX    = 3'd4;
    localparam logic [2:0] ST_CROSS = 3'd5;

    logic [2:0]               step_reg, step_next;
    logic                     done_reg;
    logic signed [DIFF_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [DIFF_W-1:0] op_a, op_b;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [DOT_W-1:0]  acc_reg, dot_reg, cross_val;
    logic                     cross_reg;

    function automatic logic signed [DIFF_W-1:0] diff(coord_t a, coord_t b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    // Pick the operand pair for the current product.
    always_comb begin
        unique case (step_reg)
            ST_XX:   begin op_a = ax_reg; op_b = bx_reg; end
            ST_YY:   begin op_a = ay_reg; op_b = by_reg; end
            ST_XY:   begin op_a = ax_reg; op_b = by_reg; end
            ST_YX:   begin op_a = ay_reg; op_b = bx_reg; end
            default: begin op_a = ax_reg; op_b = bx_reg; end
        endcase
    end

    assign prod_next = op_a * op_b;
    assign cross_val = acc_reg - DOT_W'(prod_reg);

    always_comb begin
        step_next = step_reg;
        unique case (step_reg)
            ST_IDLE:  if (req.start) begin
                step_next = ST_XX;
            end
            ST_XX:    step_next = ST_YY;
            ST_YY:    step_next = ST_XY;
            ST_XY:    step_next = ST_YX;
            ST_YX:    step_next = ST_CROSS;
            ST_CROSS: step_next = ST_IDLE;
            default:  step_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= (step_reg == ST_CROSS);
        end
    end

    always_ff @(posedge aclk) begin
        if (step_reg == ST_IDLE && req.start) begin
            ax_reg <= diff(req.ahd_x, req.cen_x);
            ay_reg <= diff(req.ahd_y, req.cen_y);
            bx_reg <= diff(req.cen_x, req.bhd_x);
            by_reg <= diff(req.cen_y, req.bhd_y);
        end
        prod_reg <= prod_next;
        if (step_reg == ST_YY || step_reg == ST_YX) begin
            acc_reg <= DOT_W'(prod_reg);
        end
        if (step_reg == ST_XY) begin
            dot_reg <= acc_reg + DOT_W'(prod_reg);
        end
        if (step_reg == ST_CROSS) begin
            cross_reg <= (cross_val > 0);
        end
    end

    assign res.done      = done_reg;
    assign res.dot       = dot_reg;
    assign res.cross_pos = cross_reg;

endmodule

/* bench/tb.sv */
// Testbench for the contour curvature endpoint finder: directed and random contours vs. a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cce_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int STORE_DEPTH     = 4096;
    localparam int COORD_MAX       = (1 << COORD_BITS) - 1;
    localparam int RANDOM_ITEMS    = 1550;
    localparam int RANDOM_CONTOURS = 40;
    localparam int HOLD_CYCLES     = 3000;
    localparam int IDLE_PAUSE      = 16;
    localparam int SETTLE_CYCLES   = 60;
    // The limit leaves room for the slowest correct run (one full store of 4096
    // points, sender gaps on every item, receiver stalls on every result).
    localparam int CYCLE_LIMIT     = 1_000_000;

    typedef enum int {SHAPE_TURTLE, SHAPE_WALK, SHAPE_NOISE, SHAPE_FLAT} shape_t;
    typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_RUNS} rx_mode_t;

    // Predicts tail and head of each closed contour and checks the block's results in order.
    class endpoint_scoreboard;
        coord_t              pt_x [STORE_DEPTH];
        coord_t              pt_y [STORE_DEPTH];
        int                  dot_val [STORE_DEPTH];
        bit                  turns_left [STORE_DEPTH];
        int unsigned         stored;
        bit                  dropped;
        logic [LSCALE_W-1:0] scale;
        logic [MSEG_W-1:0]   min_seg;
        out_item_t           expected_q [$];
        int unsigned         mismatches;

        function new();
            stored     = 0;
            dropped    = 1'b0;
            scale      = LSCALE_RESET;
            min_seg    = MSEG_RESET;
            mismatches = 0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_LENGTH_SCALE: scale = value[LSCALE_W-1:0];
                REG_MIN_SEGMENTS: min_seg = value[MSEG_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Store the point unless the store is full; close the contour on last.
        function void note_point(input in_item_t it);
            if (stored < STORE_DEPTH) begin
                pt_x[stored] = it.point_x;
                pt_y[stored] = it.point_y;
                stored++;
            end else begin
                dropped = 1'b1;
            end
            if (it.last) begin
                expected_q.push_back(predict_endpoints());
                stored  = 0;
                dropped = 1'b0;
            end
        endfunction

        // Earliest point with the smallest dot below the limit and a left turn;
        // with away set, only points more than a quarter ring from tail count.
        function int unsigned pick_extremum(input int unsigned n, input int unsigned tail,
                                            input bit away, input int unsigned fallback);
            int unsigned best_i;
            int unsigned d;
            int          best;
            best_i = fallback;
            best   = int'(CURVY_LIMIT);
            for (int unsigned i = 0; i < n; i++) begin
                d = (i > tail) ? i - tail : tail - i;
                if (n - d < d)
                    d = n - d;
                if ((!away || d > n / 4) && turns_left[i] && dot_val[i] < best) begin
                    best   = dot_val[i];
                    best_i = i;
                end
            end
            return best_i;
        endfunction

        function out_item_t predict_endpoints();
            out_item_t   r;
            int unsigned n, k, ah, bh, tail, head;
            int          ax, ay, bx, by;
            r = '0;
            n = stored;
            if (n == 0 || n < 2 * min_seg) begin
                r.status = STATUS_TOO_FEW;
                return r;
            end
            k = scale % n;
            for (int unsigned i = 0; i < n; i++) begin
                ah = (i + k) % n;
                bh = (i + n - k) % n;
                ax = int'(pt_x[ah]) - int'(pt_x[i]);
                ay = int'(pt_y[ah]) - int'(pt_y[i]);
                bx = int'(pt_x[i]) - int'(pt_x[bh]);
                by = int'(pt_y[i]) - int'(pt_y[bh]);
                dot_val[i]    = ax * bx + ay * by;
                turns_left[i] = (ax * by - ay * bx) > 0;
            end
            tail = pick_extremum(n, 0, 1'b0, 0);
            head = pick_extremum(n, tail, 1'b1, (tail + n / 2) % n);
            r.status     = dropped ? STATUS_OVERFLOW : STATUS_OK;
            r.tail_index = IDX_OUT_W'(tail);
            r.head_index = IDX_OUT_W'(head);
            r.tail_x     = pt_x[tail];
            r.tail_y     = pt_y[tail];
            r.head_x     = pt_x[head];
            r.head_y     = pt_y[head];
            return r;
        endfunction

        function void check_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
            if (got !== want) begin
                $display("%0t ERROR: %s expected %0d, got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_endpoints(input out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                $display("%0t ERROR: result with nothing expected, got status %0d tail %0d head %0d",
                         $time, got.status, got.tail_index, got.head_index);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            check_field("status", want.status, got.status);
            check_field("tail_index", want.tail_index, got.tail_index);
            check_field("head_index", want.head_index, got.head_index);
            check_field("tail_x", want.tail_x, got.tail_x);
            check_field("tail_y", want.tail_y, got.tail_y);
            check_field("head_x", want.head_x, got.head_x);
            check_field("head_y", want.head_y, got.head_y);
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    endpoint_scoreboard sb;
    int unsigned        burst_left;
    int unsigned        cycle_count;
    bit                 hold_req;

    contour_curvature_endpoints DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic in_item_t mk_point(input int x, input int y, input bit last);
        in_item_t it;
        it.point_x = coord_t'(x);
        it.point_y = coord_t'(y);
        it.last    = last;
        return it;
    endfunction

    // Step in x for one of eight compass headings; y uses the heading turned back by 90 degrees.
    function automatic int heading_dx(input int h);
        case (h)
            0, 1, 7: return 1;
            3, 4, 5: return -1;
            default: return 0;
        endcase
    endfunction

    // Offer one item from a falling edge and hold it until accepted. The sender
    // works in bursts; between bursts drop valid for a random gap, or skip the
    // gap now and then so long back-to-back stretches occur too.
    task automatic push_point(input in_item_t it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_point(it);
        @(negedge aclk);
    endtask

    // Send one closed contour of len points; last is set on the final point.
    task automatic send_contour(input int unsigned len, input shape_t shape);
        int x, y, head, bias, step;
        x    = $urandom_range(0, COORD_MAX);
        y    = $urandom_range(0, COORD_MAX);
        head = $urandom_range(0, 7);
        bias = int'($urandom_range(0, 2)) - 1;
        for (int unsigned i = 0; i < len; i++) begin
            case (shape)
                SHAPE_TURTLE: begin
                    // Mostly turn one way so the path bends like an outline, with stray wiggles.
                    if ($urandom_range(0, 2) == 0)
                        head = (head + 8 + bias) % 8;
                    else if ($urandom_range(0, 5) == 0)
                        head = (head + 7 + int'($urandom_range(0, 2))) % 8;
                    step = $urandom_range(1, 12);
                    x += step * heading_dx(head);
                    y += step * heading_dx((head + 6) % 8);
                end
                SHAPE_WALK: begin
                    x += int'($urandom_range(0, 60)) - 30;
                    y += int'($urandom_range(0, 60)) - 30;
                end
                SHAPE_NOISE: begin
                    x = $urandom_range(0, COORD_MAX);
                    y = $urandom_range(0, COORD_MAX);
                end
                default: begin
                    // Mostly repeated points: zero vectors and ties, with rare jumps.
                    if ($urandom_range(0, 7) == 0) begin
                        x = $urandom_range(0, COORD_MAX);
                        y = $urandom_range(0, COORD_MAX);
                    end
                end
            endcase
            x = (x < 0) ? 0 : ((x > COORD_MAX) ? COORD_MAX : x);
            y = (y < 0) ? 0 : ((y > COORD_MAX) ? COORD_MAX : y);
            push_point(mk_point(x, y, i == len - 1));
        end
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic wait_idle(input int unsigned pause);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (pause) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        sb.set_register(idx, value);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Stimulus: directed contours, one contour past the store size, then random phases.
    initial begin
        logic [LSCALE_W-1:0]   scale;
        logic [CFG_DATA_W-1:0] value;
        int unsigned           len, rand_items, rand_contours, contours_left;
        shape_t                shape;

        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        burst_left = 0;
        hold_req   = 1'b0;
        sb         = new();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings need 200 points: three corners of the coordinate range are too few.
        push_point(mk_point(0, 0, 1'b0));
        push_point(mk_point(COORD_MAX, COORD_MAX, 1'b0));
        push_point(mk_point(COORD_MAX, 0, 1'b1));

        // Zero offset and no minimum: every vector vanishes, tail 0, head half way round.
        wait_idle(IDLE_PAUSE);
        write_register(REG_LENGTH_SCALE, '0);
        write_register(REG_MIN_SEGMENTS, '0);
        push_point(mk_point(COORD_MAX, 0, 1'b1));
        push_point(mk_point(0, COORD_MAX, 1'b0));
        push_point(mk_point(COORD_MAX, COORD_MAX, 1'b0));
        push_point(mk_point(COORD_MAX, 0, 1'b0));
        push_point(mk_point(0, 0, 1'b1));

        // Largest offset wraps round an octagon (255 mod 8 looks one point back).
        wait_idle(IDLE_PAUSE);
        write_register(REG_LENGTH_SCALE, CFG_DATA_W'(255));
        write_register(REG_MIN_SEGMENTS, CFG_DATA_W'(2));
        push_point(mk_point(100, 0, 1'b0));
        push_point(mk_point(200, 0, 1'b0));
        push_point(mk_point(300, 100, 1'b0));
        push_point(mk_point(300, 200, 1'b0));
        push_point(mk_point(200, 300, 1'b0));
        push_point(mk_point(100, 300, 1'b0));
        push_point(mk_point(0, 200, 1'b0));
        push_point(mk_point(0, 100, 1'b1));

        // Smallest offset on a rectangle: equal dots at the corners, earliest index wins.
        wait_idle(IDLE_PAUSE);
        write_register(REG_LENGTH_SCALE, CFG_DATA_W'(1));
        write_register(REG_MIN_SEGMENTS, CFG_DATA_W'(3));
        push_point(mk_point(0, 0, 1'b0));
        push_point(mk_point(0, 10, 1'b0));
        push_point(mk_point(10, 10, 1'b0));
        push_point(mk_point(20, 10, 1'b0));
        push_point(mk_point(20, 0, 1'b0));
        push_point(mk_point(10, 0, 1'b1));

        // Largest minimum: a short contour falls short, then fill the store past
        // its end so the tail points, the last one included, are dropped.
        wait_idle(IDLE_PAUSE);
        write_register(REG_LENGTH_SCALE, CFG_DATA_W'($urandom_range(1, 255)));
        write_register(REG_MIN_SEGMENTS, CFG_DATA_W'(STORE_DEPTH / 2));
        send_contour(12, SHAPE_NOISE);
        send_contour(STORE_DEPTH + 3, SHAPE_TURTLE);

        // Random phases: new settings while idle, then a handful of contours each.
        rand_items    = 0;
        rand_contours = 0;
        while (rand_items < RANDOM_ITEMS || rand_contours < RANDOM_CONTOURS) begin
            wait_idle(IDLE_PAUSE);
            case ($urandom_range(0, 9))
                0:       scale = '0;
                1:       scale = LSCALE_W'(1);
                2:       scale = LSCALE_W'(255);
                3, 4, 5: scale = LSCALE_W'($urandom_range(1, 6));
                default: scale = LSCALE_W'($urandom_range(1, 255));
            endcase
            // Fill the unused upper data bits with noise; the register keeps the low bits.
            value                 = CFG_DATA_W'($urandom);
            value[LSCALE_W-1:0]   = scale;
            write_register(REG_LENGTH_SCALE, value);
            case ($urandom_range(0, 9))
                0:       value = '0;
                1:       value = CFG_DATA_W'($urandom_range(0, 40));
                default: value = CFG_DATA_W'($urandom_range(0, 6));
            endcase
            write_register(REG_MIN_SEGMENTS, value);
            // Ask the receiver for its long hold-off; it acts on this once.
            hold_req = 1'b1;
            contours_left = $urandom_range(3, 10);
            repeat (contours_left) begin
                case ($urandom_range(0, 19))
                    0:       len = $urandom_range(1, 3);
                    1:       len = $urandom_range(100, 250);
                    default: len = $urandom_range(4, 40);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: shape = SHAPE_TURTLE;
                    4, 5:       shape = SHAPE_WALK;
                    6, 7, 8:    shape = SHAPE_NOISE;
                    default:    shape = SHAPE_FLAT;
                endcase
                send_contour(len, shape);
                rand_items += len;
                rand_contours++;
            end
        end

        wait_idle(SETTLE_CYCLES);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Receiver: switch between stall modes at random; once, hold off long
    // while the sender keeps offering, so the block backs up its input.
    initial begin
        rx_mode_t    mode;
        int unsigned mode_left, run_left, phase;
        bit          level, hold_done;
        m_ready   = 1'b0;
        mode      = RX_ALWAYS;
        mode_left = 0;
        run_left  = 0;
        phase     = 0;
        level     = 1'b1;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(50, 400);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_ALWAYS:   m_ready <= 1'b1;
                    RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: m_ready <= (phase % 5) != 0;
                    default: begin
                        // Alternate runs of ready and stall of random length.
                        if (run_left == 0) begin
                            level    = !level;
                            run_left = level ? $urandom_range(1, 10) : $urandom_range(1, 25);
                        end
                        run_left--;
                        m_ready <= level;
                    end
                endcase
            end
        end
    end

    // Check each result accepted at a rising edge against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_endpoints(m_data);
    end

    // Bound the run in case the block hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t ERROR: timeout after %0d cycles", $time, cycle_count);
        $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
hdl/cce_pkg.sv
hdl/cce_ram.sv
hdl/cce_curv.sv
hdl/contour_curvature_endpoints.sv
bench/tb.sv
